[rtl/lug_pkg.sv]
// shared types and constants for the lehmer uniform generator
package lug_pkg;

    localparam int SEED_W      = 31;
    localparam int DATA_W      = 32;
    localparam int MULT_W      = 15;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [MULT_W-1:0] LCG_MULT   = 15'd16807;
    localparam logic [SEED_W:0]   LCG_MOD    = 32'h7FFF_FFFF;
    localparam logic [SEED_W-1:0] SEED_RESET = 31'd123456789;

    // register index taken from paddr above the byte offset
    typedef enum logic [APB_ADDR_W-3:0] {
        REG_SEED_START = 1'b0
    } reg_idx_t;

    typedef enum logic {
        KIND_REAL = 1'b0,
        KIND_INT  = 1'b1
    } kind_t;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] bound_a;
        logic signed [DATA_W-1:0] bound_b;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drawn_value;
        logic [SEED_W-1:0]        seed_after;
        logic                     seed_error;
    } rsp_t;

    // one classified draw waiting for the scaling back end
    typedef struct packed {
        logic                     kind;
        logic                     err;
        logic [SEED_W-1:0]        seed;
        logic signed [DATA_W-1:0] bound_a;
        logic signed [DATA_W-1:0] bound_b;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [SEED_W-1:0] data;
    } cfg_wr_t;

endpackage

[rtl/lug_front.sv]
// front end: takes draw requests, advances the seed and queues the job
module lug_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lug_pkg::cfg_wr_t            cfg_wr,
    input  lug_pkg::req_t               req,
    input  logic                        req_valid,
    output logic                        req_ready,
    output lug_pkg::job_t               job,
    output logic                        job_push,
    input  logic                        job_full,
    output logic [lug_pkg::SEED_W-1:0]  seed_start
);
    import lug_pkg::*;

    logic [SEED_W-1:0]        seed_start_reg;
    logic [SEED_W-1:0]        seed_start_next;
    logic [SEED_W-1:0]        cur_seed_reg;
    logic [SEED_W-1:0]        cur_seed_next;
    logic [SEED_W+MULT_W-1:0] prod;
    logic [SEED_W:0]          fold;
    logic [SEED_W:0]          fold_red;
    logic [SEED_W-1:0]        seed_adv;
    logic                     seed_zero;
    logic                     req_fire;

    assign req_ready = !job_full;
    assign req_fire  = req_valid && req_ready;
    assign seed_zero = (cur_seed_reg == '0);

    // seed * 16807 mod (2^31-1): fold the bits above 31 back onto the low part
    always_comb
    begin
        prod     = {{MULT_W{1'b0}}, cur_seed_reg} * {{SEED_W{1'b0}}, LCG_MULT};
        fold     = {1'b0, prod[SEED_W-1:0]}
                 + {{(SEED_W+1-MULT_W){1'b0}}, prod[SEED_W+MULT_W-1:SEED_W]};
        fold_red = (fold >= LCG_MOD) ? (fold - LCG_MOD) : fold;
        seed_adv = fold_red[SEED_W-1:0];
    end

    always_comb
    begin
        seed_start_next = seed_start_reg;
        cur_seed_next   = cur_seed_reg;
        if (req_fire && !seed_zero)
        begin
            cur_seed_next = seed_adv;
        end
        if (cfg_wr.en)
        begin
            seed_start_next = cfg_wr.data;
            cur_seed_next   = cfg_wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_start_reg <= SEED_RESET;
            cur_seed_reg   <= SEED_RESET;
        end
        else
        begin
            seed_start_reg <= seed_start_next;
            cur_seed_reg   <= cur_seed_next;
        end
    end

    always_comb
    begin
        job.kind    = req.kind;
        job.err     = seed_zero;
        job.seed    = seed_zero ? '0 : seed_adv;
        job.bound_a = req.bound_a;
        job.bound_b = req.bound_b;
    end

    assign job_push   = req_fire;
    assign seed_start = seed_start_reg;

    // a zero seed stays stuck until reloaded
    a_zero_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && seed_zero && !cfg_wr.en |=> cur_seed_reg == '0)
        else $error("zero seed left the error state without a reload");

endmodule

[rtl/lug_queue.sv]
// short job queue between front and back end
module lug_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  lug_pkg::job_t wr_job,
    input  logic          push,
    output logic          full,
    output lug_pkg::job_t rd_job,
    output logic          rd_valid,
    input  logic          pop
);
    import lug_pkg::*;

    job_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;
    assign rd_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("job queue count beyond depth");

endmodule

[rtl/lug_back.sv]
// back end: scales the advanced seed into the requested interval
module lug_back (
    input  logic          clk,
    input  logic          rst_n,
    input  lug_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_pop,
    output lug_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_ready
);
    import lug_pkg::*;

    typedef struct packed {
        logic                     kind;
        logic                     err;
        logic [SEED_W-1:0]        seed;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
    } ctl_t;

    // stage 1: bounds ordered, span formed
    logic                     v1_reg;
    logic                     v1_next;
    ctl_t                     c1_reg;
    logic signed [DATA_W:0]   d1_reg;
    // stage 2: product
    logic                     v2_reg;
    logic                     v2_next;
    ctl_t                     c2_reg;
    logic signed [63:0]       p2_reg;
    // stage 3: quotient by 2^31
    logic                     v3_reg;
    logic                     v3_next;
    ctl_t                     c3_reg;
    logic signed [DATA_W:0]   q3_reg;
    // output register
    logic                     vo_reg;
    logic                     vo_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    logic                     rdy_o;
    logic                     rdy3;
    logic                     rdy2;
    logic                     rdy1;
    logic                     swap;
    ctl_t                     c1_next;
    logic signed [DATA_W:0]   d1_next;
    logic signed [64:0]       prod_full;
    logic [63:0]              sum3;
    logic signed [DATA_W+1:0] val;
    logic signed [DATA_W+1:0] hi_ext;

    assign rdy_o   = !vo_reg || rsp_ready;
    assign rdy3    = !v3_reg || rdy_o;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign job_pop = job_valid && rdy1;

    // integer draws take the bounds in order, real draws keep them as given
    always_comb
    begin
        swap         = (job.kind == KIND_INT) && (job.bound_b < job.bound_a);
        c1_next.kind = job.kind;
        c1_next.err  = job.err;
        c1_next.seed = job.seed;
        c1_next.lo   = swap ? job.bound_b : job.bound_a;
        c1_next.hi   = swap ? job.bound_a : job.bound_b;
        d1_next      = {c1_next.hi[DATA_W-1], c1_next.hi} - {c1_next.lo[DATA_W-1], c1_next.lo};
    end

    // signed 33 x 32 bit product of span and seed
    assign prod_full = 65'(d1_reg * $signed({1'b0, c1_reg.seed}));

    // (hi - lo + 1) * seed = (hi - lo) * seed + seed for integer draws
    always_comb
    begin
        if (c2_reg.kind == KIND_INT)
        begin
            sum3 = p2_reg + {33'd0, c2_reg.seed};
        end
        else
        begin
            sum3 = p2_reg;
        end
    end

    always_comb
    begin
        val    = {{2{c3_reg.lo[DATA_W-1]}}, c3_reg.lo} + {q3_reg[DATA_W], q3_reg};
        hi_ext = {{2{c3_reg.hi[DATA_W-1]}}, c3_reg.hi};
        rsp_next.seed_after = c3_reg.seed;
        rsp_next.seed_error = c3_reg.err;
        if (c3_reg.err)
        begin
            rsp_next.drawn_value = '0;
            rsp_next.seed_after  = '0;
        end
        else if (c3_reg.kind == KIND_INT && val > hi_ext)
        begin
            rsp_next.drawn_value = c3_reg.hi;
        end
        else
        begin
            rsp_next.drawn_value = val[DATA_W-1:0];
        end
    end

    always_comb
    begin
        v1_next = rdy1 ? job_valid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        vo_next = rdy_o ? v3_reg : vo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            c1_reg <= c1_next;
            d1_reg <= d1_next;
        end
        if (rdy2)
        begin
            c2_reg <= c1_reg;
            p2_reg <= prod_full[63:0];
        end
        if (rdy3)
        begin
            c3_reg <= c2_reg;
            q3_reg <= sum3[63:31];
        end
        if (rdy_o)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = vo_reg;

    a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.seed_error |-> rsp.drawn_value == '0 && rsp.seed_after == '0)
        else $error("error response carries a value");

    a_stage3_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && rdy_o |=> vo_reg)
        else $error("draw lost between last stage and output");

endmodule

[rtl/lehmer_uniform_generator.sv]
// top level: apb register port, front end, job queue and scaling back end
// Draws from a Park-Miller generator (seed*16807 mod 2^31-1) scaled into
// [bound_a, bound_b]. One request is taken every clock while the job queue is
// not full: the seed update is a combinational fold in the front end.
// A response passes the queue write, span, multiply, divide by 2^31 and
// output register stages in order; each can stall on back-pressure.
// Writing seed_start (address 0) reloads the running seed; a zero seed
// answers every request with seed_error set until it is reloaded.
module lehmer_uniform_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lug_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lug_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lug_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  lug_pkg::req_t                     req,
    input  logic                              req_valid,
    output logic                              req_ready,
    output lug_pkg::rsp_t                     rsp,
    output logic                              rsp_valid,
    input  logic                              rsp_ready
);
    import lug_pkg::*;

    cfg_wr_t           cfg_wr;
    reg_idx_t          reg_idx;
    logic [SEED_W-1:0] seed_start;
    job_t              front_job;
    logic              front_push;
    logic              q_full;
    job_t              q_job;
    logic              q_valid;
    logic              q_pop;

    // word aligned register map, byte offset bits ignored
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_wr.en   = psel && penable && pwrite && (reg_idx == REG_SEED_START);
        cfg_wr.data = pwdata[SEED_W-1:0];
    end

    always_comb
    begin
        case (reg_idx)
            REG_SEED_START: prdata = {{(APB_DATA_W-SEED_W){1'b0}}, seed_start};
            default:        prdata = '0;
        endcase
    end

    lug_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .req        (req),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .job        (front_job),
        .job_push   (front_push),
        .job_full   (q_full),
        .seed_start (seed_start)
    );

    lug_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_job   (front_job),
        .push     (front_push),
        .full     (q_full),
        .rd_job   (q_job),
        .rd_valid (q_valid),
        .pop      (q_pop)
    );

    lug_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_job),
        .job_valid (q_valid),
        .job_pop   (q_pop),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule
